/* rtl/lsc_pkg.sv */
// Shared constants and types for the line segment clipper.
package lsc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int NUM_W   = COORD_BITS + FRAC_BITS;
    localparam int R_W     = NUM_W + 1;
    localparam int T_W     = FRAC_BITS + 1;
    localparam int PROD_W  = T_W + 1 + DIFF_W;
    localparam int EDGES   = 4;

    localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS  = 4 * COORD_BITS + 2;
    localparam int OUT_TDATA_W = ((OUT_FIELDS + 7) / 8) * 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [T_W-1:0]    T_ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PROD_W-1:0] TRUNC_BIAS = {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    localparam logic signed [COORD_BITS-1:0] LEFT_RST   = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] RIGHT_RST  = COORD_BITS'(255);
    localparam logic signed [COORD_BITS-1:0] TOP_RST    = COORD_BITS'(0);
    localparam logic signed [COORD_BITS-1:0] BOTTOM_RST = COORD_BITS'(191);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_TOP    = 2'd2,
        REG_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [DIFF_W-1:0]     dx;
        logic signed [DIFF_W-1:0]     dy;
        logic                         acc;
        logic [EDGES-1:0]             pz;
        logic [EDGES-1:0]             pn;
        logic [EDGES-1:0]             qn;
    } side_t;

    typedef struct packed {
        logic           ok;
        logic [T_W-1:0] t0;
        logic [T_W-1:0] t1;
    } edge_t;

endpackage

/* rtl/lsc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module lsc_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [lsc_pkg::NUM_W-1:0]     num,
    input  logic [lsc_pkg::COORD_BITS-1:0] den,
    output logic [lsc_pkg::NUM_W-1:0]     quo
);
    import lsc_pkg::*;

    logic [NUM_W-1:0]      num_reg [NUM_W-1];
    logic [COORD_BITS-1:0] den_reg [NUM_W-1];
    logic [COORD_BITS-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0]      quo_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [NUM_W-1:0]      num_in;
        logic [NUM_W-1:0]      quo_in;
        logic [COORD_BITS-1:0] rem_in;
        logic [COORD_BITS-1:0] den_in;
        logic [COORD_BITS:0]   trial;
        logic [COORD_BITS:0]   diff;
        logic                  fits;

        if (k == 0)
        begin : g_first
            assign num_in = num;
            assign den_in = den;
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
                quo_reg[k] <= {quo_in[NUM_W-2:0], fits};
            end
        end

        if (k < NUM_W - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= num_in << 1;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

/* rtl/line_segment_clipper.sv */
// Liang-Barsky line segment clipper, top level.
//
// Usage: segments enter on the s_axis stream, one beat per segment, and
// results leave on the m_axis stream, one beat per segment, in order.
// The clip window sits in four registers written through cfg_we, cfg_addr
// and cfg_data (left, right, top, bottom); write them only while idle.
// The pipeline has a setup stage, the divider stages (one quotient bit per
// stage, four dividers side by side, one per window edge), an edge-update
// stage for left/right and one for top/bottom, a multiply stage and
// the output register. Throughput is one segment per cycle while
// m_axis_tready does not hold the pipeline.
// Reset clears all valid bits and loads the window with left 0, right 255,
// top 0, bottom 191.
// When the receiver holds m_axis_tready low with a beat waiting, the whole
// pipeline holds and s_axis_tready falls; nothing is lost or repeated.
module line_segment_clipper (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lsc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [lsc_pkg::COORD_BITS-1:0]      cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // start_x, start_y, end_x, end_y
    input  logic [lsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // visible, clipped_start_x, clipped_start_y, clipped_end_x,
    // clipped_end_y, single_point, zero fill
    output logic [lsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import lsc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = DIFF_W;
    localparam int DIV_STAGES_P1 = NUM_W + 1;

    function automatic edge_t apply_edge(edge_t s, logic pz, logic pn, logic qn,
                                         logic signed [R_W-1:0] r);
        edge_t                 o;
        logic signed [R_W-1:0] a0;
        logic signed [R_W-1:0] a1;
        o  = s;
        a0 = R_W'(s.t0);
        a1 = R_W'(s.t1);
        if (s.ok)
        begin
            if (pz)
            begin
                o.ok = !qn;
            end
            else if (pn)
            begin
                if (r > a1)
                    o.ok = 1'b0;
                else if (r > a0)
                    o.t0 = T_W'(r);
            end
            else
            begin
                if (r < a0)
                    o.ok = 1'b0;
                else if (r < a1)
                    o.t1 = T_W'(r);
            end
        end
        return o;
    endfunction

    function automatic logic signed [CB-1:0] lerp(logic signed [CB-1:0] base,
                                                  logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] adj;
        logic signed [PROD_W-1:0] sh;
        adj = prod[PROD_W-1] ? prod + $signed(TRUNC_BIAS) : prod;
        sh  = adj >>> FRAC_BITS;
        return base + sh[CB-1:0];
    endfunction

    function automatic logic signed [R_W-1:0] signed_quo(logic [NUM_W-1:0] q, logic neg);
        logic signed [R_W-1:0] v;
        v = R_W'(q);
        return neg ? -v : v;
    endfunction

    logic en;

    logic signed [CB-1:0] left_reg, right_reg, top_reg, bottom_reg;

    // setup stage
    logic signed [CB-1:0] in_x1, in_y1, in_x2, in_y2;
    logic signed [DW-1:0] in_dx, in_dy;
    logic signed [DW-1:0] in_q [EDGES];
    logic [CB-1:0]        in_qmag [EDGES];
    logic [CB-1:0]        in_pmag [EDGES];
    side_t                in_side;

    logic [CB-1:0]    qmag_reg [EDGES];
    logic [CB-1:0]    pmag_reg [EDGES];
    logic [NUM_W-1:0] quo [EDGES];

    side_t side_reg [DIV_STAGES_P1];
    logic  vld_reg  [DIV_STAGES_P1];

    edge_t                 e1_next, e2_next;
    edge_t                 e1_st_reg, e2_st_reg;
    logic signed [R_W-1:0] e1_r2_reg, e1_r3_reg;
    side_t                 e1_side_reg, e2_side_reg, m_side_reg;
    logic                  e1_vld_reg, e2_vld_reg, m_vld_reg;
    logic                  m_ok_reg;

    logic signed [PROD_W-1:0] pcx1_reg, pcy1_reg, pcx2_reg, pcy2_reg;

    logic signed [CB-1:0] o_cx1, o_cy1, o_cx2, o_cy2;
    logic                 o_vis, o_sp;

    logic                   out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            top_reg    <= TOP_RST;
            bottom_reg <= BOTTOM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_LEFT:   left_reg   <= cfg_data;
                REG_RIGHT:  right_reg  <= cfg_data;
                REG_TOP:    top_reg    <= cfg_data;
                REG_BOTTOM: bottom_reg <= cfg_data;
                default:    left_reg   <= left_reg;
            endcase
        end
    end

    assign in_x1 = s_axis_tdata[CB-1:0];
    assign in_y1 = s_axis_tdata[2*CB-1:CB];
    assign in_x2 = s_axis_tdata[3*CB-1:2*CB];
    assign in_y2 = s_axis_tdata[4*CB-1:3*CB];
    assign in_dx = DW'(in_x2) - DW'(in_x1);
    assign in_dy = DW'(in_y2) - DW'(in_y1);

    assign in_q[0] = DW'(in_x1) - DW'(left_reg);
    assign in_q[1] = DW'(right_reg) - DW'(in_x1);
    assign in_q[2] = DW'(in_y1) - DW'(top_reg);
    assign in_q[3] = DW'(bottom_reg) - DW'(in_y1);

    assign in_pmag[0] = in_dx[DW-1] ? CB'(-in_dx) : CB'(in_dx);
    assign in_pmag[1] = in_pmag[0];
    assign in_pmag[2] = in_dy[DW-1] ? CB'(-in_dy) : CB'(in_dy);
    assign in_pmag[3] = in_pmag[2];

    for (genvar e = 0; e < EDGES; e++)
    begin : g_qmag
        assign in_qmag[e]    = in_q[e][DW-1] ? CB'(-in_q[e]) : CB'(in_q[e]);
        assign in_side.qn[e] = in_q[e][DW-1];
        assign in_side.pz[e] = (in_pmag[e] == '0);
    end

    assign in_side.pn[0] = !in_dx[DW-1] && (in_dx != '0);
    assign in_side.pn[1] = in_dx[DW-1];
    assign in_side.pn[2] = !in_dy[DW-1] && (in_dy != '0);
    assign in_side.pn[3] = in_dy[DW-1];
    assign in_side.x1    = in_x1;
    assign in_side.y1    = in_y1;
    assign in_side.dx    = in_dx;
    assign in_side.dy    = in_dy;
    assign in_side.acc   = (in_x1 >= left_reg) && (in_x1 <= right_reg) &&
                           (in_x2 >= left_reg) && (in_x2 <= right_reg) &&
                           (in_y1 >= top_reg) && (in_y1 <= bottom_reg) &&
                           (in_y2 >= top_reg) && (in_y2 <= bottom_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int e = 0; e < EDGES; e++)
            begin
                qmag_reg[e] <= in_qmag[e];
                pmag_reg[e] <= in_pmag[e];
            end
            for (int k = 1; k < DIV_STAGES_P1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES_P1; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k < DIV_STAGES_P1; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    for (genvar e = 0; e < EDGES; e++)
    begin : g_div
        lsc_div u_div (
            .clk (clk),
            .en  (en),
            .num ({qmag_reg[e], {FRAC_BITS{1'b0}}}),
            .den (pmag_reg[e]),
            .quo (quo[e])
        );
    end

    // left and right edges
    always_comb
    begin
        side_t s;
        edge_t st;
        s  = side_reg[DIV_STAGES_P1-1];
        st = '{ok: 1'b1, t0: '0, t1: T_ONE};
        st = apply_edge(st, s.pz[0], s.pn[0], s.qn[0],
                        signed_quo(quo[0], s.pn[0] ^ s.qn[0]));
        st = apply_edge(st, s.pz[1], s.pn[1], s.qn[1],
                        signed_quo(quo[1], s.pn[1] ^ s.qn[1]));
        e1_next = st;
    end

    // top and bottom edges
    always_comb
    begin
        edge_t st;
        st = apply_edge(e1_st_reg, e1_side_reg.pz[2], e1_side_reg.pn[2],
                        e1_side_reg.qn[2], e1_r2_reg);
        st = apply_edge(st, e1_side_reg.pz[3], e1_side_reg.pn[3],
                        e1_side_reg.qn[3], e1_r3_reg);
        e2_next = st;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_st_reg   <= e1_next;
            e1_r2_reg   <= signed_quo(quo[2], side_reg[DIV_STAGES_P1-1].pn[2] ^
                                              side_reg[DIV_STAGES_P1-1].qn[2]);
            e1_r3_reg   <= signed_quo(quo[3], side_reg[DIV_STAGES_P1-1].pn[3] ^
                                              side_reg[DIV_STAGES_P1-1].qn[3]);
            e1_side_reg <= side_reg[DIV_STAGES_P1-1];
            e2_st_reg   <= e2_next;
            e2_side_reg <= e1_side_reg;
            pcx1_reg    <= $signed({1'b0, e2_st_reg.t0}) * e2_side_reg.dx;
            pcy1_reg    <= $signed({1'b0, e2_st_reg.t0}) * e2_side_reg.dy;
            pcx2_reg    <= $signed({1'b0, e2_st_reg.t1}) * e2_side_reg.dx;
            pcy2_reg    <= $signed({1'b0, e2_st_reg.t1}) * e2_side_reg.dy;
            m_ok_reg    <= e2_st_reg.ok;
            m_side_reg  <= e2_side_reg;
        end
    end

    always_comb
    begin
        if (m_side_reg.acc)
        begin
            o_vis = 1'b1;
            o_cx1 = m_side_reg.x1;
            o_cy1 = m_side_reg.y1;
            o_cx2 = m_side_reg.x1 + m_side_reg.dx[CB-1:0];
            o_cy2 = m_side_reg.y1 + m_side_reg.dy[CB-1:0];
        end
        else if (m_ok_reg)
        begin
            o_vis = 1'b1;
            o_cx1 = lerp(m_side_reg.x1, pcx1_reg);
            o_cy1 = lerp(m_side_reg.y1, pcy1_reg);
            o_cx2 = lerp(m_side_reg.x1, pcx2_reg);
            o_cy2 = lerp(m_side_reg.y1, pcy2_reg);
        end
        else
        begin
            o_vis = 1'b0;
            o_cx1 = '0;
            o_cy1 = '0;
            o_cx2 = '0;
            o_cy2 = '0;
        end
        o_sp = o_vis && (o_cx1 == o_cx2) && (o_cy1 == o_cy2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {{(OUT_TDATA_W-OUT_FIELDS){1'b0}}, o_sp,
                             o_cy2, o_cx2, o_cy1, o_cx1, o_vis};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg  <= 1'b0;
            e2_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_vld_reg  <= vld_reg[DIV_STAGES_P1-1];
            e2_vld_reg  <= e1_vld_reg;
            m_vld_reg   <= e2_vld_reg;
            out_vld_reg <= m_vld_reg;
        end
    end

endmodule
